/* rtl/core/dump_run_address_translator_top_assert.svh */
// Assertion macros for the dump run address translator.
// Used by the port checker; needs nothing else.
`ifndef DUMP_RUN_ADDRESS_TRANSLATOR_TOP_ASSERT_SVH
`define DUMP_RUN_ADDRESS_TRANSLATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRAT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle port rule violated");

// The consequent must hold in the cycle after the antecedent.
`define DRAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle port rule violated");

`endif

/* rtl/core/drat_pkg.sv */
// Shared types and constants of the dump run address translator.
// Depends on nothing; used by the top level and the port checker.
`timescale 1ns / 1ps

package drat_pkg;

   localparam int ADDR_W = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W = ADDR_W - PAGE_SHIFT;
   localparam int HDR_W = 14;
   localparam int WORD_W = 32;
   localparam int MAX_RUNS_DEFAULT = 32;

   localparam logic [WORD_W-1:0] PAGE_MARK = 32'h4547_4150;
   localparam logic [WORD_W-1:0] VALID_WORD_RESET = 32'h504D_5544;
   localparam logic [HDR_W-1:0] HEADER_SIZE_RESET = 14'h1000;

   typedef enum logic [1:0] {
      MODE_HEADER = 2'd0,
      MODE_LOAD = 2'd1,
      MODE_TRANSLATE = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_TOO_SMALL = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic {
      REG_HEADER_SIZE = 1'b0,
      REG_VALID_WORD = 1'b1
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic [PAGE_W-1:0] start_page;
      logic [PAGE_W-1:0] length_page;
      logic [ADDR_W-1:0] bias;
   } run_entry_type;

endpackage

/* rtl/core/dump_run_address_translator_top.sv */
// Top level of the dump run address translator: header check, run table, address search.
// Depends on drat_pkg.
`timescale 1ns / 1ps

// A header check, a run load, an unused mode or a translation with no runs loaded answers
// in the cycle after the request is taken. Otherwise a translation scans the run table
// through its single read port, one run per cycle; each run read is registered, compared,
// and the outcome registered. A hit ends the scan at the first matching run, a miss after
// the last loaded run. busy falls in the same cycle the result appears, so a new request can
// be taken as it shows. The table needs no clearing after reset; results are never held off.
module dump_run_address_translator_top #(
   parameter int MAX_RUNS = drat_pkg::MAX_RUNS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_mode,
   input  logic [drat_pkg::WORD_W-1:0]          req_signature_word,
   input  logic [drat_pkg::WORD_W-1:0]          req_valid_word,
   input  logic [drat_pkg::WORD_W-1:0]          req_header_bytes,
   input  logic [drat_pkg::WORD_W-1:0]          req_run_count,
   input  logic [drat_pkg::PAGE_W-1:0]          req_base_page,
   input  logic [drat_pkg::PAGE_W-1:0]          req_page_count,
   input  logic [drat_pkg::ADDR_W-1:0]          req_address,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [drat_pkg::ADDR_W-1:0]          rsp_file_offset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int CNT_W = $clog2(MAX_RUNS + 1);
   localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int AW = drat_pkg::ADDR_W;
   localparam int PW = drat_pkg::PAGE_W;
   localparam int SH = drat_pkg::PAGE_SHIFT;

   drat_pkg::state_type state_ff, state_in;

   logic [drat_pkg::HDR_W-1:0]  header_size_ff;
   logic [drat_pkg::WORD_W-1:0] valid_word_ff;
   logic [CNT_W-1:0]            runs_expected_ff, runs_expected_in;
   logic [CNT_W-1:0]            runs_loaded_ff, runs_loaded_in;
   logic [AW-1:0]               next_offset_ff, next_offset_in;
   logic [CNT_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]               addr_ff, addr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   drat_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [AW-1:0]               rsp_offset_ff, rsp_offset_in;

   drat_pkg::run_entry_type     run_mem [MAX_RUNS];
   drat_pkg::run_entry_type     rd_data_ff;
   drat_pkg::run_entry_type     wr_data;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;

   logic                        accept;
   logic                        cfg_write;
   logic [CNT_W-1:0]            cmp_next;
   logic                        cmp_last;
   logic [PW-1:0]               addr_page;
   logic [PW-1:0]               page_dist;
   logic                        run_hit;
   logic [AW-1:0]               xlat_offset;
   logic [AW-1:0]               base_addr;
   logic [AW-1:0]               length_bytes;

   assign accept = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign busy = (state_ff == drat_pkg::ST_SEARCH);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_file_offset = rsp_offset_ff;

   always_comb begin
      case (drat_pkg::reg_index_type'(paddr[2]))
         drat_pkg::REG_HEADER_SIZE: prdata = 32'(header_size_ff);
         drat_pkg::REG_VALID_WORD:  prdata = valid_word_ff;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_size_ff <= drat_pkg::HEADER_SIZE_RESET;
         valid_word_ff <= drat_pkg::VALID_WORD_RESET;
      end else if (cfg_write) begin
         case (drat_pkg::reg_index_type'(paddr[2]))
            drat_pkg::REG_HEADER_SIZE: header_size_ff <= pwdata[drat_pkg::HDR_W-1:0];
            drat_pkg::REG_VALID_WORD:  valid_word_ff <= pwdata;
            default:                   valid_word_ff <= valid_word_ff;
         endcase
      end
   end

   assign addr_page = addr_ff[AW-1:SH];
   assign page_dist = addr_page - rd_data_ff.start_page;
   assign run_hit = (addr_page >= rd_data_ff.start_page) && (page_dist < rd_data_ff.length_page);
   assign xlat_offset = addr_ff + rd_data_ff.bias;
   assign cmp_next = cmp_idx_ff + 1'b1;
   assign cmp_last = (cmp_next == runs_loaded_ff);

   assign base_addr = {req_base_page, {SH{1'b0}}};
   assign length_bytes = {req_page_count, {SH{1'b0}}};

   always_comb begin
      state_in = state_ff;
      runs_expected_in = runs_expected_ff;
      runs_loaded_in = runs_loaded_ff;
      next_offset_in = next_offset_ff;
      cmp_idx_in = cmp_idx_ff;
      addr_in = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      wr_en = 1'b0;
      wr_addr = runs_loaded_ff[IDX_W-1:0];
      wr_data.start_page = req_base_page;
      wr_data.length_page = req_page_count;
      wr_data.bias = next_offset_ff - base_addr;
      rd_en = 1'b0;
      rd_addr = '0;

      case (state_ff)
         drat_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_offset_in = '0;
               rsp_status_in = drat_pkg::STATUS_NOT_FOUND;
               case (drat_pkg::mode_type'(req_mode))
                  drat_pkg::MODE_HEADER: begin
                     if (req_header_bytes < 32'(header_size_ff)) begin
                        rsp_status_in = drat_pkg::STATUS_TOO_SMALL;
                     end else if (req_signature_word == drat_pkg::PAGE_MARK &&
                                  req_valid_word == valid_word_ff) begin
                        runs_loaded_in = '0;
                        runs_expected_in = (req_run_count > 32'(MAX_RUNS)) ?
                                           CNT_W'(MAX_RUNS) : req_run_count[CNT_W-1:0];
                        next_offset_in = 64'(header_size_ff);
                        rsp_status_in = drat_pkg::STATUS_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  drat_pkg::MODE_LOAD: begin
                     if (runs_loaded_ff >= runs_expected_ff) begin
                        rsp_status_in = drat_pkg::STATUS_REJECTED;
                     end else begin
                        wr_en = 1'b1;
                        next_offset_in = next_offset_ff + length_bytes;
                        runs_loaded_in = runs_loaded_ff + 1'b1;
                        rsp_status_in = drat_pkg::STATUS_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  drat_pkg::MODE_TRANSLATE: begin
                     addr_in = req_address;
                     cmp_idx_in = '0;
                     if (runs_loaded_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en = 1'b1;
                        state_in = drat_pkg::ST_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         drat_pkg::ST_SEARCH: begin
            if (run_hit) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = drat_pkg::STATUS_OK;
               rsp_offset_in = xlat_offset;
               state_in = drat_pkg::ST_IDLE;
            end else if (cmp_last) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = drat_pkg::STATUS_NOT_FOUND;
               rsp_offset_in = '0;
               state_in = drat_pkg::ST_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = cmp_next[IDX_W-1:0];
               cmp_idx_in = cmp_next;
            end
         end
         default: begin
            state_in = drat_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drat_pkg::ST_IDLE;
         runs_expected_ff <= '0;
         runs_loaded_ff <= '0;
         next_offset_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         runs_expected_ff <= runs_expected_in;
         runs_loaded_ff <= runs_loaded_in;
         next_offset_ff <= next_offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      addr_ff <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= run_mem[rd_addr];
      end
   end

endmodule

/* rtl/core/drat_checker.sv */
// Port checker for the dump run address translator, bound to the top level.
// Depends on drat_pkg and dump_run_address_translator_top_assert.svh.
`timescale 1ns / 1ps
`include "dump_run_address_translator_top_assert.svh"

module drat_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_file_offset
);

   `DRAT_ASSERT_NEXT(a_quick_modes_answer, clock, reset,
      start && !busy && req_mode != drat_pkg::MODE_TRANSLATE, rsp_valid && !busy)

   `DRAT_ASSERT_NEXT(a_translate_progresses, clock, reset,
      start && !busy && req_mode == drat_pkg::MODE_TRANSLATE, rsp_valid || busy)

   `DRAT_ASSERT_SAME(a_failed_offset_zero, clock, reset,
      rsp_valid && rsp_status != drat_pkg::STATUS_OK, rsp_file_offset == '0)

   `DRAT_ASSERT_SAME(a_result_has_cause, clock, reset,
      rsp_valid, $past(start && !busy) || $past(busy))

   `DRAT_ASSERT_SAME(a_too_small_from_header, clock, reset,
      rsp_valid && rsp_status == drat_pkg::STATUS_TOO_SMALL,
      $past(start && !busy) && $past(req_mode) == drat_pkg::MODE_HEADER)

endmodule

bind dump_run_address_translator_top drat_checker u_drat_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_file_offset (rsp_file_offset)
);
